[rtl/core/tsrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_pkg
// Shared types and constants for the touch scroll report translator.
// ----------------------------------------------------------------------------
package tsrt_pkg;

  // Report filter values.
  localparam logic [7:0] REPORT_PREFIX = 8'hA1;
  localparam logic [7:0] REPORT_KIND   = 8'h12;
  localparam logic [7:0] TOUCH_LENGTH  = 8'd23;
  localparam int unsigned TOUCH_FLAG_BIT = 6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_X_LIMIT    = 2'd0,
    CFG_ZONE_Y_LIMIT    = 2'd1,
    CFG_START_THRESHOLD = 2'd2,
    CFG_STEP_THRESHOLD  = 2'd3
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam logic [7:0] ZONE_X_LIMIT_RST    = 8'd16;
  localparam logic [7:0] ZONE_Y_LIMIT_RST    = 8'hF0;
  localparam logic [7:0] START_THRESHOLD_RST = 8'd2;
  localparam logic [7:0] STEP_THRESHOLD_RST  = 8'd4;

  typedef struct packed {
    logic [7:0] zone_x_limit;
    logic [7:0] zone_y_limit;
    logic [7:0] start_threshold;
    logic [7:0] step_threshold;
  } cfg_t;

  // Touch state machine, one-hot.
  typedef enum logic [2:0] {
    ST_RELEASED  = 3'b001,
    ST_PRESSED   = 3'b010,
    ST_SCROLLING = 3'b100
  } touch_state_t;

  typedef struct packed {
    logic [7:0]  report_prefix;
    logic [7:0]  report_kind;
    logic [7:0]  button_bits;
    logic [31:0] motion_word;
    logic [7:0]  position_low;
    logic [7:0]  position_mid;
    logic [7:0]  position_y;
    logic [7:0]  touch_flags;
    logic [7:0]  report_length;
  } item_t;

  typedef struct packed {
    logic [7:0]  scroll_horizontal;
    logic [7:0]  scroll_vertical;
    logic [31:0] motion;
    logic [1:0]  buttons;
  } report_t;

  // Magnitude of an 8-bit two's complement value; -128 gives 128.
  function automatic logic [8:0] mag8(input logic [7:0] v);
    logic [8:0] m;
    if (v[7]) begin
      m = 9'd256 - {1'b0, v};
    end else begin
      m = {1'b0, v};
    end
    return m;
  endfunction

endpackage

[rtl/core/tsrt_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_cfg_regs
// Write-only configuration registers for zone limits and thresholds.
// ----------------------------------------------------------------------------
module tsrt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tsrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output tsrt_pkg::cfg_t                cfg
);

  tsrt_pkg::cfg_t cfg_r;
  tsrt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (tsrt_pkg::cfg_index_t'(cfg_index))
        tsrt_pkg::CFG_ZONE_X_LIMIT:    cfg_nxt.zone_x_limit    = cfg_data;
        tsrt_pkg::CFG_ZONE_Y_LIMIT:    cfg_nxt.zone_y_limit    = cfg_data;
        tsrt_pkg::CFG_START_THRESHOLD: cfg_nxt.start_threshold = cfg_data;
        tsrt_pkg::CFG_STEP_THRESHOLD:  cfg_nxt.step_threshold  = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_x_limit    <= tsrt_pkg::ZONE_X_LIMIT_RST;
      cfg_r.zone_y_limit    <= tsrt_pkg::ZONE_Y_LIMIT_RST;
      cfg_r.start_threshold <= tsrt_pkg::START_THRESHOLD_RST;
      cfg_r.step_threshold  <= tsrt_pkg::STEP_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/tsrt_gesture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_gesture
// Report filter, anchor differences and the released/pressed/scrolling
// state machine that produces the scroll deltas.
// ----------------------------------------------------------------------------
module tsrt_gesture (
  input  logic              clk,
  input  logic              rst_n,
  input  tsrt_pkg::cfg_t    cfg,
  input  tsrt_pkg::item_t   item,
  input  logic              advance,
  output logic              pass,
  output tsrt_pkg::report_t rep
);

  tsrt_pkg::touch_state_t state_r, state_nxt, state_eff;
  logic [7:0] anchor_x_r, anchor_x_nxt;
  logic [7:0] anchor_y_r, anchor_y_nxt;
  logic [7:0] pos_x, dx, dy, sv, sh;
  logic [8:0] mag_x, mag_y;
  logic       touched, in_zone, moved;

  assign pass = (item.report_prefix == tsrt_pkg::REPORT_PREFIX) &&
                (item.report_kind == tsrt_pkg::REPORT_KIND) &&
                (item.button_bits[7:2] == 6'd0);

  assign pos_x   = {item.position_mid[3:0], item.position_low[7:4]};
  assign dx      = pos_x - anchor_x_r;
  assign dy      = item.position_y - anchor_y_r;
  assign mag_x   = tsrt_pkg::mag8(dx);
  assign mag_y   = tsrt_pkg::mag8(dy);
  assign touched = (item.report_length == tsrt_pkg::TOUCH_LENGTH) &&
                   item.touch_flags[tsrt_pkg::TOUCH_FLAG_BIT];
  assign in_zone = ($signed(anchor_x_r) <= $signed(cfg.zone_x_limit)) &&
                   ($signed(anchor_y_r) >= $signed(cfg.zone_y_limit));
  assign moved   = (mag_x > {1'b0, cfg.start_threshold}) ||
                   (mag_y > {1'b0, cfg.start_threshold});

  always_comb begin
    sv           = 8'd0;
    sh           = 8'd0;
    state_eff    = state_r;
    state_nxt    = state_r;
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    // A lost touch while scrolling flushes the pending differences once.
    if (!touched) begin
      if (state_r == tsrt_pkg::ST_SCROLLING) begin
        sv = dy;
        sh = dx;
      end
      state_eff = tsrt_pkg::ST_RELEASED;
      state_nxt = tsrt_pkg::ST_RELEASED;
    end
    unique case (state_eff)
      tsrt_pkg::ST_RELEASED: begin
        if (touched) begin
          state_nxt    = tsrt_pkg::ST_PRESSED;
          anchor_x_nxt = pos_x;
          anchor_y_nxt = item.position_y;
        end
      end
      tsrt_pkg::ST_PRESSED: begin
        if (in_zone && moved) begin
          state_nxt    = tsrt_pkg::ST_SCROLLING;
          anchor_x_nxt = pos_x;
          anchor_y_nxt = item.position_y;
        end
      end
      tsrt_pkg::ST_SCROLLING: begin
        if (mag_y >= {1'b0, cfg.step_threshold}) begin
          anchor_y_nxt = item.position_y;
          sv           = dy;
        end
        if (mag_x >= {1'b0, cfg.step_threshold}) begin
          anchor_x_nxt = pos_x;
          sh           = dx;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tsrt_pkg::ST_RELEASED;
      anchor_x_r <= 8'd0;
      anchor_y_r <= 8'd0;
    end else if (advance && pass) begin
      state_r    <= state_nxt;
      anchor_x_r <= anchor_x_nxt;
      anchor_y_r <= anchor_y_nxt;
    end
  end

  assign rep.buttons           = item.button_bits[1:0];
  assign rep.motion            = item.motion_word;
  assign rep.scroll_vertical   = sv;
  assign rep.scroll_horizontal = sh;

  // A dropped or waiting report leaves the machine alone.
  a_hold_without_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && pass) |=> $stable(state_r) && $stable(anchor_x_r) && $stable(anchor_y_r))
    else $error("gesture state changed without a passing report");

  // Scroll deltas only come out of the scrolling state.
  a_scroll_from_scrolling: assert property (@(posedge clk) disable iff (!rst_n)
    (sv != 8'd0 || sh != 8'd0) |-> state_r == tsrt_pkg::ST_SCROLLING)
    else $error("scroll delta outside scrolling state");

  // Entering scrolling always re-anchors to the current position.
  a_scroll_entry_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pass && state_r == tsrt_pkg::ST_PRESSED &&
     state_nxt == tsrt_pkg::ST_SCROLLING) |=>
    anchor_x_r == $past(pos_x) && anchor_y_r == $past(item.position_y))
    else $error("anchor not taken on entry to scrolling");

endmodule

[rtl/core/tsrt_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_out_stage
// Duplicate suppression against the last sent report and the result register.
// ----------------------------------------------------------------------------
module tsrt_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tsrt_pkg::report_t rep,
  input  logic              out_stall,
  output logic              out_valid,
  output tsrt_pkg::report_t out_rep
);

  tsrt_pkg::report_t last_r;
  tsrt_pkg::report_t out_rep_r;
  logic              sent_r;
  logic              out_valid_r, out_valid_nxt;
  logic              emit;

  assign emit = load && !(sent_r && (rep == last_r));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
      last_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        sent_r <= 1'b1;
        last_r <= rep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rep_r <= rep;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rep   = out_rep_r;

  // The pending result is always the last report recorded as sent.
  a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rep_r == last_r) && sent_r)
    else $error("pending result differs from last sent report");

  // A new result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule

[rtl/core/touch_scroll_report_translator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_scroll_report_translator_unit
// Translates raw touch-mouse reports into standard mouse reports with
// vertical and horizontal scroll deltas, suppressing repeated reports.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   in_*     input      in_valid / in_stall    one raw touch-mouse report
//   out_*    output     out_valid / out_stall  buttons, motion, scroll deltas
//   cfg_*    input      cfg_wr_en              register index and 8-bit data
//
// One transaction can be accepted on every clock cycle while in_stall is low.
// An accepted report is held in the input register until it can advance; the
// gesture logic and duplicate check then load the result register, which
// presents it on the output channel. Reports that fail the filter or repeat the
// last sent report produce no output transaction but still update nothing or
// only the gesture state respectively. in_stall rises only when the input
// register is full and the result register is full and stalled. rst_n is
// synchronous and returns the gesture machine to released, anchors to zero and
// the registers to their defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module touch_scroll_report_translator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_report_prefix,
  input  logic [7:0]                     in_report_kind,
  input  logic [7:0]                     in_button_bits,
  input  logic [31:0]                    in_motion_word,
  input  logic [7:0]                     in_position_low,
  input  logic [7:0]                     in_position_mid,
  input  logic signed [7:0]              in_position_y,
  input  logic [7:0]                     in_touch_flags,
  input  logic [7:0]                     in_report_length,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_buttons_out,
  output logic [31:0]                    out_motion_out,
  output logic signed [7:0]              out_scroll_vertical,
  output logic signed [7:0]              out_scroll_horizontal,
  // Configuration port.
  input  logic                           cfg_wr_en,
  input  logic [tsrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  tsrt_pkg::cfg_t    cfg;
  tsrt_pkg::item_t   item_r;
  tsrt_pkg::report_t rep;
  tsrt_pkg::report_t out_rep;
  logic              item_valid_r, item_valid_nxt;
  logic              in_accept;
  logic              advance;
  logic              pass;

  // The input register moves on whenever the result register can take a
  // result this cycle, whether or not this report ends up producing one.
  assign advance   = item_valid_r && (!out_valid || !out_stall);
  assign in_stall  = item_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  // Payload register; no reset is needed as the valid bit qualifies it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.report_prefix <= in_report_prefix;
      item_r.report_kind   <= in_report_kind;
      item_r.button_bits   <= in_button_bits;
      item_r.motion_word   <= in_motion_word;
      item_r.position_low  <= in_position_low;
      item_r.position_mid  <= in_position_mid;
      item_r.position_y    <= in_position_y;
      item_r.touch_flags   <= in_touch_flags;
      item_r.report_length <= in_report_length;
    end
  end

  tsrt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsrt_gesture u_gesture (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .advance (advance),
    .pass    (pass),
    .rep     (rep)
  );

  tsrt_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && pass),
    .rep       (rep),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rep   (out_rep)
  );

  assign out_buttons_out       = out_rep.buttons;
  assign out_motion_out        = out_rep.motion;
  assign out_scroll_vertical   = out_rep.scroll_vertical;
  assign out_scroll_horizontal = out_rep.scroll_horizontal;

  // The input side only waits behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // An accepted transaction always lands in the input register.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> item_valid_r)
    else $error("accepted transaction not held");

  // A report held in the input register leaves it as soon as it can advance.
  a_advance_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_accept) |=> !item_valid_r)
    else $error("input register not drained");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch scroll report translator. A behavioural
// copy of the gesture machine predicts every mouse report, a checker compares
// each output transaction against the oldest prediction, and named test tasks
// walk through directed cases, several register settings and back-pressure.
// ----------------------------------------------------------------------------
module tb;

  // Cycles waited after the last predicted report has arrived, before touching
  // the registers or ending the run.
  localparam int DRAIN_CYCLES  = 6;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int STALL_LIMIT   = 4000;
  // Length of the deliberate long hold-off on the result channel.
  localparam int HOLD_CYCLES   = 80;

  logic clk = 1'b0;
  logic rst_n;

  logic                           in_valid;
  logic                           in_stall;
  tsrt_pkg::item_t                in_item;

  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     out_buttons_out;
  logic [31:0]                    out_motion_out;
  logic signed [7:0]              out_scroll_vertical;
  logic signed [7:0]              out_scroll_horizontal;

  logic                           cfg_wr_en;
  logic [tsrt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  // Predicted mouse reports, oldest first.
  tsrt_pkg::report_t pending_reports[$];
  int                mismatches = 0;

  // Idling control shared by both sides of the bench.
  bit idle_enable   = 1'b1;
  int hold_requests = 0;
  int holds_served  = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  // Behavioural copy of the block's state and registers.
  tsrt_pkg::cfg_t         active_cfg;
  tsrt_pkg::touch_state_t track_state;
  logic [7:0]             track_anchor_x;
  logic [7:0]             track_anchor_y;
  tsrt_pkg::report_t      last_report;
  bit                     report_seen;

  // State of the random gesture generator.
  logic [7:0] gen_x;
  logic [7:0] gen_y;
  bit         gen_touching;
  logic [31:0] gen_motion;

  touch_scroll_report_translator_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_report_prefix      (in_item.report_prefix),
    .in_report_kind        (in_item.report_kind),
    .in_button_bits        (in_item.button_bits),
    .in_motion_word        (in_item.motion_word),
    .in_position_low       (in_item.position_low),
    .in_position_mid       (in_item.position_mid),
    .in_position_y         (in_item.position_y),
    .in_touch_flags        (in_item.touch_flags),
    .in_report_length      (in_item.report_length),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_buttons_out       (out_buttons_out),
    .out_motion_out        (out_motion_out),
    .out_scroll_vertical   (out_scroll_vertical),
    .out_scroll_horizontal (out_scroll_horizontal),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Magnitude of a wrapped 8-bit difference. The most negative value has a
  // magnitude of 128, which needs the ninth bit.
  function automatic logic [8:0] delta_size(input logic [7:0] d);
    delta_size = d[7] ? (9'd0 - {1'b1, d}) : {1'b0, d};
  endfunction

  function automatic logic [7:0] y_of(input tsrt_pkg::item_t it);
    y_of = it.position_y;
  endfunction

  // Works out the mouse report, if any, that one accepted transaction causes
  // and queues it. Filtered reports leave every piece of state untouched.
  task automatic predict_report(input tsrt_pkg::item_t it);
    logic [7:0]        x;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic [7:0]        sv;
    logic [7:0]        sh;
    logic              touched;
    tsrt_pkg::report_t rep;
    if (it.report_prefix != tsrt_pkg::REPORT_PREFIX ||
        it.report_kind != tsrt_pkg::REPORT_KIND ||
        it.button_bits[7:2] != 6'd0) begin
      return;
    end
    x       = {it.position_mid[3:0], it.position_low[7:4]};
    dx      = x - track_anchor_x;
    dy      = it.position_y - track_anchor_y;
    touched = (it.report_length == tsrt_pkg::TOUCH_LENGTH) &&
              it.touch_flags[tsrt_pkg::TOUCH_FLAG_BIT];
    sv      = 8'd0;
    sh      = 8'd0;

    // Lifting the finger while scrolling flushes the pending differences once.
    if (!touched) begin
      if (track_state == tsrt_pkg::ST_SCROLLING) begin
        sv = dy;
        sh = dx;
      end
      track_state = tsrt_pkg::ST_RELEASED;
    end

    case (track_state)
      tsrt_pkg::ST_RELEASED: begin
        if (touched) begin
          track_state    = tsrt_pkg::ST_PRESSED;
          track_anchor_x = x;
          track_anchor_y = y_of(it);
        end
      end
      tsrt_pkg::ST_PRESSED: begin
        if ($signed(track_anchor_x) <= $signed(active_cfg.zone_x_limit) &&
            $signed(track_anchor_y) >= $signed(active_cfg.zone_y_limit) &&
            (delta_size(dx) > {1'b0, active_cfg.start_threshold} ||
             delta_size(dy) > {1'b0, active_cfg.start_threshold})) begin
          track_state    = tsrt_pkg::ST_SCROLLING;
          track_anchor_x = x;
          track_anchor_y = y_of(it);
        end
      end
      tsrt_pkg::ST_SCROLLING: begin
        if (delta_size(dy) >= {1'b0, active_cfg.step_threshold}) begin
          track_anchor_y = y_of(it);
          sv             = dy;
        end
        if (delta_size(dx) >= {1'b0, active_cfg.step_threshold}) begin
          track_anchor_x = x;
          sh             = dx;
        end
      end
      default: begin
      end
    endcase

    rep.buttons           = it.button_bits[1:0];
    rep.motion            = it.motion_word;
    rep.scroll_vertical   = sv;
    rep.scroll_horizontal = sh;

    // A report identical to the last one sent is suppressed, except the first.
    if (report_seen && rep == last_report) begin
      return;
    end
    last_report = rep;
    report_seen = 1'b1;
    pending_reports.push_back(rep);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Every output transaction is checked against the oldest prediction. All
  // values are read just after the edge, so they are the ones the block saw.
  always @(posedge clk) begin
    tsrt_pkg::report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report btn=%0h mot=%08h v=%02h h=%02h",
                                  out_buttons_out, out_motion_out,
                                  out_scroll_vertical, out_scroll_horizontal));
      end else begin
        want = pending_reports.pop_front();
        if (out_buttons_out !== want.buttons)
          report_mismatch($sformatf("buttons %0h, predicted %0h",
                                    out_buttons_out, want.buttons));
        if (out_motion_out !== want.motion)
          report_mismatch($sformatf("motion %08h, predicted %08h",
                                    out_motion_out, want.motion));
        if (out_scroll_vertical !== want.scroll_vertical)
          report_mismatch($sformatf("vertical scroll %02h, predicted %02h",
                                    out_scroll_vertical, want.scroll_vertical));
        if (out_scroll_horizontal !== want.scroll_horizontal)
          report_mismatch($sformatf("horizontal scroll %02h, predicted %02h",
                                    out_scroll_horizontal, want.scroll_horizontal));
      end
    end
  end

  // Watchdog: a run in which no transaction moves for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Idling and the result side
  // --------------------------------------------------------------------------

  // Mostly no gap, often a short one and now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiver stalls at random. A hold-off request from a test forces a
  // long stall, counted down here so that the sender keeps offering meanwhile.
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left   <= HOLD_CYCLES - 1;
      out_stall    <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_stall  <= 1'b1;
        stall_left <= g - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sending and configuration
  // --------------------------------------------------------------------------

  // Offers one report and holds it until the block takes it. Valid is only
  // lowered when a gap follows, so back-to-back transactions keep it high.
  task automatic send_item(input tsrt_pkg::item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_report(it);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted report has arrived, then
  // lets the pipeline empty of reports that produce nothing.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers in turn; only called while the block is idle.
  task automatic set_config(input tsrt_pkg::cfg_t c);
    logic [7:0] vals[4];
    vals[0] = c.zone_x_limit;
    vals[1] = c.zone_y_limit;
    vals[2] = c.start_threshold;
    vals[3] = c.step_threshold;
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= tsrt_pkg::cfg_index_t'(i[tsrt_pkg::CFG_IDX_W-1:0]);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    active_cfg  = c;
    @(posedge clk);
  endtask

  // A well-formed report with the x position split across the two nibbles.
  // The unused nibbles carry a mirror of x so that they toggle as well.
  function automatic tsrt_pkg::item_t make_report(input logic [7:0] btn,
                                                  input logic [31:0] motion,
                                                  input logic [7:0] x,
                                                  input logic [7:0] y,
                                                  input logic [7:0] flags,
                                                  input logic [7:0] len);
    tsrt_pkg::item_t it;
    it.report_prefix = tsrt_pkg::REPORT_PREFIX;
    it.report_kind   = tsrt_pkg::REPORT_KIND;
    it.button_bits   = btn;
    it.motion_word   = motion;
    it.position_low  = {x[3:0], x[7:4]};
    it.position_mid  = {x[3:0], x[7:4]};
    it.position_y    = y;
    it.touch_flags   = flags;
    it.report_length = len;
    return it;
  endfunction

  // Random reports shaped as gestures: press, a run of moves, lift. A small
  // share is raw noise or breaks the filter so that rejection is exercised.
  task automatic next_random_item(output tsrt_pkg::item_t it);
    int         r;
    int         step_x;
    int         step_y;
    logic [3:0] nib_lo;
    logic [3:0] nib_hi;
    logic [7:0] btn;
    logic [7:0] flags;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      it.report_prefix = ($urandom_range(0, 1) != 0) ? tsrt_pkg::REPORT_PREFIX
                                                      : 8'($urandom);
      it.report_kind   = ($urandom_range(0, 1) != 0) ? tsrt_pkg::REPORT_KIND
                                                      : 8'($urandom);
      it.button_bits   = 8'($urandom);
      it.motion_word   = $urandom;
      it.position_low  = 8'($urandom);
      it.position_mid  = 8'($urandom);
      it.position_y    = 8'($urandom);
      it.touch_flags   = 8'($urandom);
      it.report_length = 8'($urandom);
      return;
    end

    btn = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(4, 255));

    r = $urandom_range(0, 99);
    if (r < 40) gen_motion = 32'd0;
    else if (r < 60) gen_motion = gen_motion;
    else if (r < 75) gen_motion = 32'($urandom_range(0, 15));
    else gen_motion = $urandom;

    if (gen_touching && $urandom_range(0, 99) < 10) begin
      gen_touching = 1'b0;
    end else if (!gen_touching && $urandom_range(0, 99) < 70) begin
      // New press, mostly near the scrolling corner.
      gen_touching = 1'b1;
      if ($urandom_range(0, 99) < 65) begin
        gen_x = 8'($urandom_range(0, 48) - 24);
        gen_y = 8'($urandom_range(0, 48) - 24);
      end else begin
        gen_x = 8'($urandom);
        gen_y = 8'($urandom);
      end
    end else if (gen_touching) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        step_x = $urandom_range(0, 16) - 8;
        step_y = $urandom_range(0, 16) - 8;
      end else if (r < 95) begin
        step_x = $urandom_range(0, 80) - 40;
        step_y = $urandom_range(0, 80) - 40;
      end else begin
        step_x = $urandom_range(0, 255);
        step_y = $urandom_range(0, 255);
      end
      gen_x = gen_x + 8'(step_x);
      gen_y = gen_y + 8'(step_y);
    end

    if (gen_touching) begin
      flags = 8'($urandom) | 8'h40;
      len   = tsrt_pkg::TOUCH_LENGTH;
    end else if ($urandom_range(0, 1) != 0) begin
      flags = 8'($urandom) & 8'hBF;
      len   = tsrt_pkg::TOUCH_LENGTH;
    end else begin
      flags = 8'($urandom);
      len   = 8'($urandom_range(0, 254));
      if (len == tsrt_pkg::TOUCH_LENGTH) len = 8'd255;
    end

    it = make_report(btn, gen_motion, gen_x, gen_y, flags, len);
    // Scatter the nibbles that do not form x.
    nib_lo = 4'($urandom_range(0, 15));
    nib_hi = 4'($urandom_range(0, 15));
    it.position_low = {gen_x[3:0], nib_lo};
    it.position_mid = {nib_hi, gen_x[7:4]};
    // Now and then break the header of an otherwise good report.
    r = $urandom_range(0, 99);
    if (r < 3) it.report_prefix = 8'($urandom);
    else if (r < 6) it.report_kind = 8'($urandom);
  endtask

  task automatic run_random(input int count);
    tsrt_pkg::item_t it;
    for (int i = 0; i < count; i++) begin
      next_random_item(it);
      send_item(it);
    end
  endtask

  function automatic tsrt_pkg::cfg_t random_cfg();
    tsrt_pkg::cfg_t c;
    c.zone_x_limit    = 8'($urandom);
    c.zone_y_limit    = 8'($urandom);
    c.start_threshold = 8'($urandom_range(0, 128));
    c.step_threshold  = 8'($urandom_range(0, 128));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Directed walk at the reset settings: first report, duplicates, the
  // filter, the whole gesture machine, wrapped differences, touch loss and
  // field extremes.
  task automatic test_directed_reports();
    tsrt_pkg::item_t it;
    logic [7:0]      tl;
    tl = tsrt_pkg::TOUCH_LENGTH;
    // The first passing report is sent even though it is all zero.
    it = make_report(8'd0, 32'd0, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(it);
    // An identical report is suppressed.
    send_item(it);
    // Filtered reports: wrong prefix, wrong kind, stray button bits.
    it = make_report(8'd1, 32'h1234_5678, 8'h10, 8'h10, 8'h40, tl);
    it.report_prefix = 8'h00;
    send_item(it);
    it = make_report(8'd1, 32'h1234_5678, 8'h10, 8'h10, 8'h40, tl);
    it.report_kind = 8'hFF;
    send_item(it);
    send_item(make_report(8'h04, 32'h1, 8'h00, 8'h00, 8'h40, tl));
    send_item(make_report(8'hFF, 32'h1, 8'h00, 8'h00, 8'h40, tl));
    // Press in the corner, then move past the start threshold to scroll.
    send_item(make_report(8'd1, 32'h1, 8'h00, 8'h00, 8'h40, tl));
    send_item(make_report(8'd1, 32'h1, 8'h03, 8'h00, 8'h40, tl));
    // A vertical jump of -128, whose magnitude is 128.
    send_item(make_report(8'd1, 32'h1, 8'h03, 8'h80, 8'h40, tl));
    // A horizontal step that wraps below zero.
    send_item(make_report(8'd1, 32'h1, 8'hFF, 8'h80, 8'h40, tl));
    // Touch lost through a short report while scrolling flushes both deltas.
    send_item(make_report(8'd2, 32'h1, 8'h7F, 8'h7F, 8'h40, 8'd22));
    // Press at the most negative x and the top y, move under threshold, then cross it.
    send_item(make_report(8'd3, 32'h2, 8'h80, 8'h7F, 8'hFF, tl));
    send_item(make_report(8'd3, 32'h2, 8'h80, 8'h7D, 8'hFF, tl));
    send_item(make_report(8'd3, 32'h2, 8'h7B, 8'h7D, 8'hFF, tl));
    // Touch lost through the flag bit with a good length.
    send_item(make_report(8'd0, 32'h2, 8'h7B, 8'h7D, 8'h00, tl));
    // Press outside the zone: large moves never start scrolling.
    send_item(make_report(8'd0, 32'h3, 8'h40, 8'h00, 8'h40, tl));
    send_item(make_report(8'd0, 32'h3, 8'h60, 8'hC0, 8'h40, tl));
    send_item(make_report(8'd1, 32'h3, 8'h60, 8'hC0, 8'hBF, 8'd255));
    // Extremes of the pass-through fields.
    send_item(make_report(8'd3, 32'hFFFF_FFFF, 8'hFF, 8'h80, 8'hFF, tl));
    send_item(make_report(8'd3, 32'hFFFF_FFFF, 8'hFF, 8'h80, 8'hFF, tl));
    send_item(make_report(8'd0, 32'hAAAA_5555, 8'h00, 8'h00, 8'h00, 8'd0));
    run_random(80);
  endtask

  // Extreme register values: everything scrolls, then nothing can.
  task automatic test_register_extremes();
    tsrt_pkg::cfg_t c;
    wait_drain();
    c = '{zone_x_limit: 8'h7F, zone_y_limit: 8'h80, start_threshold: 8'd0,
          step_threshold: 8'd0};
    set_config(c);
    run_random(120);
    wait_drain();
    c = '{zone_x_limit: 8'h80, zone_y_limit: 8'h7F, start_threshold: 8'd128,
          step_threshold: 8'd128};
    set_config(c);
    run_random(120);
    wait_drain();
    // Thresholds above the largest magnitude never trigger.
    c = '{zone_x_limit: 8'h7F, zone_y_limit: 8'h80, start_threshold: 8'hFF,
          step_threshold: 8'hFF};
    set_config(c);
    run_random(80);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 2; p++) begin
      wait_drain();
      set_config(random_cfg());
      run_random(120);
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_no_idle();
    wait_drain();
    set_config('{zone_x_limit: 8'd16, zone_y_limit: 8'hF0, start_threshold: 8'd2,
                 step_threshold: 8'd4});
    idle_enable = 1'b0;
    run_random(80);
    idle_enable = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block fills and stalls its input. Distinct motion words make sure
  // every transaction produces a report.
  task automatic test_backpressure();
    wait_drain();
    idle_enable = 1'b0;
    hold_requests++;
    for (int i = 0; i < 30; i++) begin
      send_item(make_report(8'(i % 4), 32'h0001_0000 + 32'(i), 8'h00, 8'h00,
                            8'h00, 8'd0));
    end
    idle_enable = 1'b1;
  endtask

  // The sender pauses mid-stream until every predicted report has arrived.
  task automatic test_sender_pause();
    run_random(40);
    wait_drain();
    run_random(40);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= tsrt_pkg::CFG_ZONE_X_LIMIT;
    cfg_data  <= 8'd0;

    active_cfg     = '{zone_x_limit: tsrt_pkg::ZONE_X_LIMIT_RST,
                       zone_y_limit: tsrt_pkg::ZONE_Y_LIMIT_RST,
                       start_threshold: tsrt_pkg::START_THRESHOLD_RST,
                       step_threshold: tsrt_pkg::STEP_THRESHOLD_RST};
    track_state    = tsrt_pkg::ST_RELEASED;
    track_anchor_x = 8'd0;
    track_anchor_y = 8'd0;
    last_report    = '0;
    report_seen    = 1'b0;
    gen_x          = 8'd0;
    gen_y          = 8'd0;
    gen_touching   = 1'b0;
    gen_motion     = 32'd0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_reports();
    test_register_extremes();
    test_random_settings();
    test_no_idle();
    test_backpressure();
    test_sender_pause();
    wait_drain();
    set_config(random_cfg());
    run_random(100);
    wait_drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
